// ===== src/sixteen_bit_risc_step_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SIXTEEN_BIT_RISC_STEP_CORE_ASSERT_SVH
`define SIXTEEN_BIT_RISC_STEP_CORE_ASSERT_SVH
// same-cycle implication
`define SBRS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SBRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/sbrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_pkg
// Types, constants and helpers for the 16-bit RISC step core.
// ----------------------------------------------------------------------------
package sbrs_pkg;
   localparam int ADDR_BITS = 16;
   localparam int MEM_WORDS = 1 << ADDR_BITS;
   localparam logic [15:0] KBSR_ADDR = 16'hFE00;
   localparam logic [15:0] KBDR_ADDR = 16'hFE02;
   localparam logic [15:0] PC_RESET  = 16'h3000;
   localparam logic [2:0]  CC_RESET  = 3'd2;
   localparam logic [15:0] KB_READY_WORD = 16'h8000;

   localparam logic [1:0] CMD_EXEC  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_SETPC = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_TRAP    = 2'd1;
   localparam logic [1:0] STAT_ILLEGAL = 2'd2;

   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DATA, S_KB1, S_KB2, S_EXEC, S_FIN
   } state_type;

   typedef enum logic [2:0] {
      P_FETCH, P_CMD2, P_PTR, P_STIPTR, P_LOAD
   } phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] pc_value;
      logic [15:0] instr_word;
      logic [7:0]  trap_vector;
      logic        reg_we;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic [2:0]  cond_flags;
      logic        mem_we;
      logic [15:0] mem_addr;
      logic [15:0] mem_data;
   } result_type;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      if (v == 16'd0) return 3'd2;
      if (v[15]) return 3'd4;
      return 3'd1;
   endfunction

   function automatic logic [15:0] sext9(input logic [15:0] ir);
      return {{7{ir[8]}}, ir[8:0]};
   endfunction

   function automatic logic [15:0] sext6(input logic [15:0] ir);
      return {{10{ir[5]}}, ir[5:0]};
   endfunction

   function automatic logic [15:0] sext5(input logic [15:0] ir);
      return {{11{ir[4]}}, ir[4:0]};
   endfunction

   function automatic logic [15:0] sext11(input logic [15:0] ir);
      return {{5{ir[10]}}, ir[10:0]};
   endfunction
endpackage
`default_nettype wire

// ===== src/sbrs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_req_if / sbrs_rsp_if
// Valid/ready channels for commands and step results.
// ----------------------------------------------------------------------------
interface sbrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] addr;
   logic [15:0] data;
   logic        key_ready;
   logic [7:0]  key_char;
   modport source (output valid, cmd, addr, data, key_ready, key_char, input ready);
   modport sink (input valid, cmd, addr, data, key_ready, key_char, output ready);
endinterface

interface sbrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] pc_value;
   logic [15:0] instr_word;
   logic [7:0]  trap_vector;
   logic        reg_we;
   logic [2:0]  reg_index;
   logic [15:0] reg_value;
   logic [2:0]  cond_flags;
   logic        mem_we;
   logic [15:0] mem_addr;
   logic [15:0] mem_data;
   modport source (output valid, status, pc_value, instr_word, trap_vector, reg_we,
      reg_index, reg_value, cond_flags, mem_we, mem_addr, mem_data, input ready);
   modport sink (input valid, status, pc_value, instr_word, trap_vector, reg_we,
      reg_index, reg_value, cond_flags, mem_we, mem_addr, mem_data, output ready);
endinterface
`default_nettype wire

// ===== src/sbrs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sbrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) mem[addr] <= wdata;
         rdata <= mem[addr];
      end
   end
endmodule
`default_nettype wire

// ===== src/sixteen_bit_risc_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sixteen_bit_risc_step_core
// LC-3 style core executing one command per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries a command (execute, write word, read word, set PC) with
//    the keyboard inputs; rsp_ch returns exactly one result transaction each.
//  - All memory accesses go through one single-port 64K x 16 RAM, one access
//    per cycle, with read data returned in the next cycle.
//  - Write and set-PC need no RAM read; read word does one read, instructions
//    one fetch; loads add one or two reads, stores one write; a keyboard
//    status read adds a status write and, with a key ready, a data write.
//  - The sequence of RAM accesses (fetch, pointer, load, store) sets the
//    rate; a new transaction is taken as soon as the sequencer is idle,
//    even while the previous result still waits in the output register.
//  - A stalled receiver holds the result; the sequencer finishes the next
//    command and then waits for the output register before going idle.
//  - Reset: registers zero, PC 0x3000, condition code Z. The RAM is not
//    cleared; reading never-written words returns unspecified data.
// ----------------------------------------------------------------------------
module sixteen_bit_risc_step_core (
   input wire logic   clock,
   input wire logic   reset,
   sbrs_req_if.sink   req_ch,
   sbrs_rsp_if.source rsp_ch
);
   sbrs_pkg::state_type  state_ff, state_in;
   sbrs_pkg::phase_type  phase_ff, phase_in;
   sbrs_pkg::result_type res_ff, res_in, out_ff, out_in;
   logic        ovalid_ff, ovalid_in;
   logic [15:0] addr_ff, addr_in;
   logic        kr_ff, kr_in;
   logic [7:0]  kc_ff, kc_in;
   logic [15:0] raddr_ff, raddr_in;
   logic [15:0] rd_ff, rd_in;
   logic [15:0] rf_ff [8];
   logic [15:0] rf_in [8];
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  cc_ff, cc_in;

   logic        m_en, m_we;
   logic [15:0] m_addr, m_wdata, m_rdata;

   logic        accept;
   logic [15:0] ir, pc_n, opb, wval;
   logic [3:0]  op;
   logic [2:0]  rd_idx, rs1;

   sbrs_ram #(.WIDTH(16), .DEPTH(sbrs_pkg::MEM_WORDS)) u_ram (
      .clock (clock),
      .en    (m_en),
      .we    (m_we),
      .addr  (m_addr[sbrs_pkg::ADDR_BITS-1:0]),
      .wdata (m_wdata),
      .rdata (m_rdata)
   );

   assign req_ch.ready = (state_ff == sbrs_pkg::S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign ir     = (phase_ff == sbrs_pkg::P_FETCH) ? rd_ff : res_ff.instr_word;
   assign op     = ir[15:12];
   assign rd_idx = ir[11:9];
   assign rs1    = ir[8:6];
   assign pc_n   = pc_ff + 16'd1;
   assign opb    = ir[5] ? sbrs_pkg::sext5(ir) : rf_ff[ir[2:0]];

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      res_in    = res_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff;
      addr_in   = addr_ff;
      kr_in     = kr_ff;
      kc_in     = kc_ff;
      raddr_in  = raddr_ff;
      rd_in     = rd_ff;
      rf_in     = rf_ff;
      pc_in     = pc_ff;
      cc_in     = cc_ff;
      m_en      = 1'b0;
      m_we      = 1'b0;
      m_addr    = raddr_ff;
      m_wdata   = 16'd0;
      wval      = 16'd0;

      if (ovalid_ff && rsp_ch.ready) ovalid_in = 1'b0;

      unique case (state_ff)
         sbrs_pkg::S_IDLE: begin
            if (accept) begin
               res_in  = '0;
               addr_in = req_ch.addr;
               kr_in   = req_ch.key_ready;
               kc_in   = req_ch.key_char;
               unique case (req_ch.cmd)
                  sbrs_pkg::CMD_WRITE: begin
                     m_en    = 1'b1;
                     m_we    = 1'b1;
                     m_addr  = req_ch.addr;
                     m_wdata = req_ch.data;
                     res_in.mem_we   = 1'b1;
                     res_in.mem_addr = req_ch.addr;
                     res_in.mem_data = req_ch.data;
                     state_in = sbrs_pkg::S_FIN;
                  end
                  sbrs_pkg::CMD_READ: begin
                     raddr_in = req_ch.addr;
                     phase_in = sbrs_pkg::P_CMD2;
                     state_in = sbrs_pkg::S_READ;
                  end
                  sbrs_pkg::CMD_SETPC: begin
                     pc_in    = req_ch.addr;
                     state_in = sbrs_pkg::S_FIN;
                  end
                  default: begin
                     raddr_in = pc_ff;
                     phase_in = sbrs_pkg::P_FETCH;
                     state_in = sbrs_pkg::S_READ;
                  end
               endcase
            end
         end
         sbrs_pkg::S_READ: begin
            m_en     = 1'b1;
            state_in = sbrs_pkg::S_DATA;
         end
         sbrs_pkg::S_DATA: begin
            if (raddr_ff == sbrs_pkg::KBSR_ADDR) begin
               rd_in    = kr_ff ? sbrs_pkg::KB_READY_WORD : 16'd0;
               state_in = sbrs_pkg::S_KB1;
            end else begin
               rd_in    = m_rdata;
               state_in = sbrs_pkg::S_EXEC;
            end
         end
         sbrs_pkg::S_KB1: begin
            m_en     = 1'b1;
            m_we     = 1'b1;
            m_addr   = sbrs_pkg::KBSR_ADDR;
            m_wdata  = rd_ff;
            state_in = kr_ff ? sbrs_pkg::S_KB2 : sbrs_pkg::S_EXEC;
         end
         sbrs_pkg::S_KB2: begin
            m_en     = 1'b1;
            m_we     = 1'b1;
            m_addr   = sbrs_pkg::KBDR_ADDR;
            m_wdata  = {8'd0, kc_ff};
            state_in = sbrs_pkg::S_EXEC;
         end
         sbrs_pkg::S_EXEC: begin
            state_in = sbrs_pkg::S_FIN;
            unique case (phase_ff)
               sbrs_pkg::P_CMD2: begin
                  res_in.mem_addr = addr_ff;
                  res_in.mem_data = rd_ff;
               end
               sbrs_pkg::P_PTR: begin
                  raddr_in = rd_ff;
                  phase_in = sbrs_pkg::P_LOAD;
                  state_in = sbrs_pkg::S_READ;
               end
               sbrs_pkg::P_STIPTR: begin
                  m_en    = 1'b1;
                  m_we    = 1'b1;
                  m_addr  = rd_ff;
                  m_wdata = rf_ff[rd_idx];
                  res_in.mem_we   = 1'b1;
                  res_in.mem_addr = rd_ff;
                  res_in.mem_data = rf_ff[rd_idx];
               end
               sbrs_pkg::P_LOAD: begin
                  res_in.mem_addr  = raddr_ff;
                  res_in.mem_data  = rd_ff;
                  res_in.reg_we    = 1'b1;
                  res_in.reg_index = rd_idx;
                  res_in.reg_value = rd_ff;
                  rf_in[rd_idx]    = rd_ff;
                  cc_in            = sbrs_pkg::flags_of(rd_ff);
               end
               default: begin
                  // instruction just fetched
                  res_in.instr_word = ir;
                  pc_in = pc_n;
                  case (op)
                     sbrs_pkg::OP_ADD, sbrs_pkg::OP_AND, sbrs_pkg::OP_NOT,
                     sbrs_pkg::OP_LEA: begin
                        if (op == sbrs_pkg::OP_ADD) wval = rf_ff[rs1] + opb;
                        else if (op == sbrs_pkg::OP_AND) wval = rf_ff[rs1] & opb;
                        else if (op == sbrs_pkg::OP_NOT) wval = ~rf_ff[rs1];
                        else wval = pc_n + sbrs_pkg::sext9(ir);
                        res_in.reg_we    = 1'b1;
                        res_in.reg_index = rd_idx;
                        res_in.reg_value = wval;
                        rf_in[rd_idx]    = wval;
                        cc_in            = sbrs_pkg::flags_of(wval);
                     end
                     sbrs_pkg::OP_BR: begin
                        if ((ir[11:9] & cc_ff) != 3'd0) pc_in = pc_n + sbrs_pkg::sext9(ir);
                     end
                     sbrs_pkg::OP_JMP: pc_in = rf_ff[rs1];
                     sbrs_pkg::OP_JSR: begin
                        res_in.reg_we    = 1'b1;
                        res_in.reg_index = 3'd7;
                        res_in.reg_value = pc_n;
                        rf_in[7]         = pc_n;
                        pc_in = ir[11] ? pc_n + sbrs_pkg::sext11(ir) : rf_ff[rs1];
                     end
                     sbrs_pkg::OP_LD: begin
                        raddr_in = pc_n + sbrs_pkg::sext9(ir);
                        phase_in = sbrs_pkg::P_LOAD;
                        state_in = sbrs_pkg::S_READ;
                     end
                     sbrs_pkg::OP_LDR: begin
                        raddr_in = rf_ff[rs1] + sbrs_pkg::sext6(ir);
                        phase_in = sbrs_pkg::P_LOAD;
                        state_in = sbrs_pkg::S_READ;
                     end
                     sbrs_pkg::OP_LDI: begin
                        raddr_in = pc_n + sbrs_pkg::sext9(ir);
                        phase_in = sbrs_pkg::P_PTR;
                        state_in = sbrs_pkg::S_READ;
                     end
                     sbrs_pkg::OP_STI: begin
                        raddr_in = pc_n + sbrs_pkg::sext9(ir);
                        phase_in = sbrs_pkg::P_STIPTR;
                        state_in = sbrs_pkg::S_READ;
                     end
                     sbrs_pkg::OP_ST, sbrs_pkg::OP_STR: begin
                        wval = (op == sbrs_pkg::OP_ST) ? pc_n + sbrs_pkg::sext9(ir)
                                                       : rf_ff[rs1] + sbrs_pkg::sext6(ir);
                        m_en    = 1'b1;
                        m_we    = 1'b1;
                        m_addr  = wval;
                        m_wdata = rf_ff[rd_idx];
                        res_in.mem_we   = 1'b1;
                        res_in.mem_addr = wval;
                        res_in.mem_data = rf_ff[rd_idx];
                     end
                     sbrs_pkg::OP_TRAP: begin
                        res_in.status      = sbrs_pkg::STAT_TRAP;
                        res_in.trap_vector = ir[7:0];
                     end
                     default: res_in.status = sbrs_pkg::STAT_ILLEGAL;
                  endcase
               end
            endcase
         end
         sbrs_pkg::S_FIN: begin
            if (!ovalid_ff || rsp_ch.ready) begin
               out_in            = res_ff;
               out_in.pc_value   = pc_ff;
               out_in.cond_flags = cc_ff;
               ovalid_in         = 1'b1;
               state_in          = sbrs_pkg::S_IDLE;
            end
         end
         default: state_in = sbrs_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sbrs_pkg::S_IDLE;
         phase_ff  <= sbrs_pkg::P_FETCH;
         ovalid_ff <= 1'b0;
         pc_ff     <= sbrs_pkg::PC_RESET;
         cc_ff     <= sbrs_pkg::CC_RESET;
         for (int i = 0; i < 8; i++) rf_ff[i] <= 16'd0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         ovalid_ff <= ovalid_in;
         pc_ff     <= pc_in;
         cc_ff     <= cc_in;
         rf_ff     <= rf_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      out_ff   <= out_in;
      addr_ff  <= addr_in;
      kr_ff    <= kr_in;
      kc_ff    <= kc_in;
      raddr_ff <= raddr_in;
      rd_ff    <= rd_in;
   end

   assign rsp_ch.valid       = ovalid_ff;
   assign rsp_ch.status      = out_ff.status;
   assign rsp_ch.pc_value    = out_ff.pc_value;
   assign rsp_ch.instr_word  = out_ff.instr_word;
   assign rsp_ch.trap_vector = out_ff.trap_vector;
   assign rsp_ch.reg_we      = out_ff.reg_we;
   assign rsp_ch.reg_index   = out_ff.reg_index;
   assign rsp_ch.reg_value   = out_ff.reg_value;
   assign rsp_ch.cond_flags  = out_ff.cond_flags;
   assign rsp_ch.mem_we      = out_ff.mem_we;
   assign rsp_ch.mem_addr    = out_ff.mem_addr;
   assign rsp_ch.mem_data    = out_ff.mem_data;
endmodule
`default_nettype wire

// ===== src/sbrs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrs_checker
// Port-level checks on the step core's result channel.
// ----------------------------------------------------------------------------
`include "sixteen_bit_risc_step_core_assert.svh"
module sbrs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  status,
   input wire logic [7:0]  trap_vector,
   input wire logic        reg_we,
   input wire logic [2:0]  reg_index,
   input wire logic [15:0] reg_value,
   input wire logic        mem_we,
   input wire logic [2:0]  cond_flags
);
   `SBRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `SBRS_ASSERT_NOW(a_fault_no_write, rsp_valid && status != sbrs_pkg::STAT_OK, !reg_we && !mem_we)
   `SBRS_ASSERT_NOW(a_vec_only_trap, rsp_valid && trap_vector != 8'd0, status == sbrs_pkg::STAT_TRAP)
   `SBRS_ASSERT_NOW(a_idle_reg, rsp_valid && !reg_we, reg_index == 3'd0 && reg_value == 16'd0)
   `SBRS_ASSERT_NOW(a_cc_onehot, rsp_valid, $onehot(cond_flags))
endmodule

bind sixteen_bit_risc_step_core sbrs_checker u_sbrs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .status      (rsp_ch.status),
   .trap_vector (rsp_ch.trap_vector),
   .reg_we      (rsp_ch.reg_we),
   .reg_index   (rsp_ch.reg_index),
   .reg_value   (rsp_ch.reg_value),
   .mem_we      (rsp_ch.mem_we),
   .cond_flags  (rsp_ch.cond_flags)
);
`default_nettype wire
